### rtl/mlbc_pkg.sv
// Shared types and constants for the multi-LED blink controller.
// No dependencies.
`timescale 1ns / 1ps

package mlbc_pkg;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned MODE_W  = 8;
  localparam int unsigned BLINK_W = 9;
  localparam int unsigned CNT_W   = 6;

  localparam logic [MODE_W-1:0] MODE_OFF = 8'h00;
  localparam logic [MODE_W-1:0] MODE_ON  = 8'hFF;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_SET    = 2'd1,
    REQ_TOGGLE = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_SEL,
    ST_TICK_WAIT,
    ST_SCAN,
    ST_SET_WR,
    ST_TOGGLE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_rsp_t;

endpackage

### rtl/mlbc_mod_unit.sv
// Bit-serial restoring modulo: 32-bit tick count modulo an 8-bit divisor.
// Depends on mlbc_pkg.
`timescale 1ns / 1ps

module mlbc_mod_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mlbc_pkg::TICK_W-1:0]  dividend_i,
  input  logic [mlbc_pkg::MODE_W-1:0]  divisor_i,
  output mlbc_pkg::div_rsp_t           rsp_o
);
  import mlbc_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TICK_W-1:0] num_q, num_d;
  logic [MODE_W-1:0] den_q, den_d;
  logic [MODE_W-1:0] rem_q, rem_d;
  logic [MODE_W:0]   trial;
  logic [MODE_W:0]   diff;

  assign trial = {rem_q, num_q[TICK_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[TICK_W-2:0], 1'b0};
      rem_d = (trial >= {1'b0, den_q}) ? diff[MODE_W-1:0] : trial[MODE_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(TICK_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

### rtl/multi_led_blink_controller_core.sv
// Multi-LED blink controller top level: sequencer, LED state and output register.
// Depends on mlbc_pkg and mlbc_mod_unit.
// Sequencing: tick walks every LED, using the serial modulo unit for blinking LEDs;
//   set scans all LEDs, then writes; toggle flips the phase; others only respond.
// One item at a time: a new request is accepted only in the idle state.
// Reset: all LEDs off, phases, repeats and tick counter cleared, level mask all ones.
`timescale 1ns / 1ps

module multi_led_blink_controller_core #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // active_level_mask
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // led_index, mode, repeat_count
  input  logic [1:0]  s_axis_tuser,    // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // lit_mask, pin_levels, led_mode
  output logic        m_axis_tuser     // ok
);
  import mlbc_pkg::*;

  localparam int unsigned IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IW-1:0] LAST = IW'(LED_COUNT - 1);

  state_e              state_q, state_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [7:0]          alm_q;
  logic [1:0]          req_q;
  logic [7:0]          id_q;
  logic [MODE_W-1:0]   mode_q;
  logic [7:0]          rep_q;
  logic                valid_q;
  logic                cp_hit_q, cp_hit_d;
  logic                cp_phase_q, cp_phase_d;

  logic [MODE_W-1:0]   modes_q [LED_COUNT];
  logic                phase_q [LED_COUNT];
  logic [BLINK_W-1:0]  blk_q   [LED_COUNT];
  logic                lit_q   [LED_COUNT];

  logic                out_valid_q;
  logic                ok_q;
  logic [7:0]          lit_mask_q, pin_q, led_mode_q;

  logic                in_acc, out_load;
  logic                sel_idx;
  logic [IW-1:0]       addr;
  logic [MODE_W-1:0]   cur_mode;
  logic                cur_phase;
  logic [BLINK_W-1:0]  cur_blk;
  logic                we_mode, we_phase, we_blk, we_lit;
  logic [MODE_W-1:0]   wd_mode;
  logic                wd_phase, wd_lit;
  logic [BLINK_W-1:0]  wd_blk;
  logic                nphase;
  logic                div_start;
  div_rsp_t            div_rsp;
  logic [7:0]          lit_mask;
  logic                ok_val;

  mlbc_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tick_q),
    .divisor_i  (cur_mode),
    .rsp_o      (div_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign sel_idx   = (state_q == ST_TICK_SEL) || (state_q == ST_TICK_WAIT) ||
                     (state_q == ST_SCAN);
  assign addr      = sel_idx ? idx_q : id_q[IW-1:0];
  assign cur_mode  = modes_q[addr];
  assign cur_phase = phase_q[addr];
  assign cur_blk   = blk_q[addr];
  assign nphase    = cur_phase ^ div_rsp.rem_zero;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    tick_d     = tick_q;
    cp_hit_d   = cp_hit_q;
    cp_phase_d = cp_phase_q;
    we_mode    = 1'b0;
    we_phase   = 1'b0;
    we_blk     = 1'b0;
    we_lit     = 1'b0;
    wd_mode    = mode_q;
    wd_phase   = cur_phase;
    wd_blk     = '0;
    wd_lit     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d    = '0;
          cp_hit_d = 1'b0;
          case (s_axis_tuser)
            REQ_TICK: begin
              tick_d  = tick_q + TICK_W'(1);
              state_d = ST_TICK_SEL;
            end
            REQ_SET:    state_d = (s_axis_tdata[7:0] < 8'(LED_COUNT)) ? ST_SCAN : ST_RESP;
            REQ_TOGGLE: state_d = (s_axis_tdata[7:0] < 8'(LED_COUNT)) ? ST_TOGGLE : ST_RESP;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_TICK_SEL: begin
        if (cur_mode == MODE_ON || cur_mode == MODE_OFF) begin
          we_lit = 1'b1;
          wd_lit = (cur_mode == MODE_ON);
          if (idx_q == LAST) begin
            state_d = ST_RESP;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end else begin
          div_start = 1'b1;
          state_d   = ST_TICK_WAIT;
        end
      end
      ST_TICK_WAIT: begin
        if (div_rsp.done) begin
          we_phase = 1'b1;
          wd_phase = nphase;
          we_lit   = 1'b1;
          wd_lit   = nphase;
          if (div_rsp.rem_zero && nphase && cur_blk != '0) begin
            we_blk = 1'b1;
            wd_blk = cur_blk - BLINK_W'(1);
            if (cur_blk == BLINK_W'(1)) begin
              we_mode = 1'b1;
              wd_mode = MODE_OFF;
            end
          end
          if (idx_q == LAST) begin
            state_d = ST_RESP;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = ST_TICK_SEL;
          end
        end
      end
      ST_SCAN: begin
        if (8'(idx_q) != id_q && cur_mode == mode_q) begin
          cp_hit_d   = 1'b1;
          cp_phase_d = cur_phase;
        end
        if (idx_q == LAST) begin
          state_d = ST_SET_WR;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_SET_WR: begin
        we_mode  = 1'b1;
        we_blk   = 1'b1;
        we_phase = 1'b1;
        wd_blk   = (rep_q != '0) ? ({1'b0, rep_q} + BLINK_W'(1)) : '0;
        if (rep_q != '0) begin
          wd_phase = 1'b0;
        end else if (cur_mode != mode_q && mode_q != MODE_ON && mode_q != MODE_OFF &&
                     cp_hit_q) begin
          wd_phase = cp_phase_q;
        end
        state_d = ST_RESP;
      end
      ST_TOGGLE: begin
        we_phase = 1'b1;
        wd_phase = ~cur_phase;
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < 8; g++) begin : g_mask
    if (g < LED_COUNT) begin : g_on
      assign lit_mask[g] = lit_q[g];
    end else begin : g_off
      assign lit_mask[g] = 1'b0;
    end
  end

  assign ok_val = (req_q == REQ_TICK) ||
                  (((req_q == REQ_SET) || (req_q == REQ_TOGGLE)) && valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      tick_q      <= '0;
      alm_q       <= 8'hFF;
      cp_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LED_COUNT; i++) begin
        modes_q[i] <= MODE_OFF;
        phase_q[i] <= 1'b0;
        blk_q[i]   <= '0;
        lit_q[i]   <= 1'b0;
      end
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      tick_q   <= tick_d;
      cp_hit_q <= cp_hit_d;
      if (cfg_we_i) begin
        alm_q <= cfg_wdata_i;
      end
      if (we_mode) begin
        modes_q[addr] <= wd_mode;
      end
      if (we_phase) begin
        phase_q[addr] <= wd_phase;
      end
      if (we_blk) begin
        blk_q[addr] <= wd_blk;
      end
      if (we_lit) begin
        lit_q[addr] <= wd_lit;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cp_phase_q <= cp_phase_d;
    if (in_acc) begin
      req_q   <= s_axis_tuser;
      id_q    <= s_axis_tdata[7:0];
      mode_q  <= s_axis_tdata[15:8];
      rep_q   <= s_axis_tdata[23:16];
      valid_q <= (s_axis_tdata[7:0] < 8'(LED_COUNT));
    end
    if (out_load) begin
      ok_q       <= ok_val;
      lit_mask_q <= lit_mask;
      pin_q      <= ~(lit_mask ^ alm_q);
      led_mode_q <= valid_q ? cur_mode : MODE_OFF;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {led_mode_q, pin_q, lit_mask_q};
  assign m_axis_tuser  = ok_q;

endmodule

### verif/tb.sv
// Self-checking bench for multi_led_blink_controller_core: directed and random request
// items, checked against an in-bench LED bank predictor. Uses mlbc_pkg.
`timescale 1ns / 1ps

module tb;
  import mlbc_pkg::*;

  localparam int unsigned LEDS        = 8;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned END_CYCLES  = 300;
  localparam int unsigned N_RANDOM    = 1000;

  typedef struct packed {
    logic [7:0] repeat_count;
    logic [7:0] mode;
    logic [7:0] led_index;
  } led_req_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] led_mode;
    logic [7:0] pin_levels;
    logic [7:0] lit_mask;
  } led_status_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  // predicted LED bank state
  logic [TICK_W-1:0]  tick_cnt;
  logic [MODE_W-1:0]  led_mode_r [LEDS];
  logic               phase_r    [LEDS];
  logic [BLINK_W-1:0] blinks_r   [LEDS];
  logic               lit_r      [LEDS];
  logic [7:0]         level_mask;

  led_status_t status_q[$];
  int          err_count;
  int          hold_requests;
  int          burst_left;
  bit          no_gaps;

  multi_led_blink_controller_core #(
    .LED_COUNT(LEDS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic led_req_t led_item(input logic [7:0] idx, input logic [7:0] mode,
                                        input logic [7:0] rep);
    led_req_t it;
    it.led_index    = idx;
    it.mode         = mode;
    it.repeat_count = rep;
    return it;
  endfunction

  function automatic led_status_t led_bank_apply(input logic [1:0] req, input led_req_t it);
    led_status_t st;
    logic        valid;
    logic [7:0]  lit;
    int          id;
    valid = (it.led_index < 8'(LEDS));
    id    = int'(it.led_index);
    st.ok = 1'b0;
    case (req)
      REQ_TICK: begin
        tick_cnt = tick_cnt + TICK_W'(1);
        for (int i = 0; i < LEDS; i++) begin
          if (led_mode_r[i] == MODE_ON) begin
            lit_r[i] = 1'b1;
          end else if (led_mode_r[i] == MODE_OFF) begin
            lit_r[i] = 1'b0;
          end else begin
            if (tick_cnt % TICK_W'(led_mode_r[i]) == '0) begin
              phase_r[i] = ~phase_r[i];
              if (phase_r[i] && blinks_r[i] != '0) begin
                blinks_r[i] = blinks_r[i] - BLINK_W'(1);
                if (blinks_r[i] == '0) led_mode_r[i] = MODE_OFF;
              end
            end
            lit_r[i] = phase_r[i];
          end
        end
        st.ok = 1'b1;
      end
      REQ_SET: begin
        if (valid) begin
          if (it.repeat_count != '0) begin
            phase_r[id] = 1'b0;
          end else if (led_mode_r[id] != it.mode && it.mode != MODE_ON &&
                       it.mode != MODE_OFF) begin
            // last other LED already in this mode wins
            for (int i = 0; i < LEDS; i++)
              if (i != id && led_mode_r[i] == it.mode) phase_r[id] = phase_r[i];
          end
          blinks_r[id]   = (it.repeat_count != '0) ?
                           BLINK_W'(it.repeat_count) + BLINK_W'(1) : '0;
          led_mode_r[id] = it.mode;
          st.ok = 1'b1;
        end
      end
      REQ_TOGGLE: begin
        if (valid) begin
          phase_r[id] = ~phase_r[id];
          st.ok = 1'b1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < LEDS; i++) lit[i] = lit_r[i];
    st.lit_mask   = lit;
    st.pin_levels = ~(lit ^ level_mask);
    st.led_mode   = valid ? led_mode_r[id] : '0;
    return st;
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic send_item(input logic [1:0] req, input led_req_t it);
    int gap;
    if (burst_left == 0 && !no_gaps) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    status_q.push_back(led_bank_apply(req, it));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_level_mask(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    level_mask = value;
    @(posedge clk_i);
  endtask

  // receiver: stall pattern in stretches, plus long hold-offs on request
  initial begin
    int phase_left;
    int style;
    int hold_left;
    int served;
    m_axis_tready = 1'b0;
    phase_left = 0;
    style      = 0;
    hold_left  = 0;
    served     = 0;
    forever begin
      @(posedge clk_i);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          style      = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    led_status_t got;
    led_status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (status_q.size() == 0) begin
        $error("unexpected result item %h", got);
        err_count++;
      end else begin
        want = status_q.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          err_count++;
        end
        if (got.lit_mask !== want.lit_mask) begin
          $error("lit_mask: expected %h, got %h", want.lit_mask, got.lit_mask);
          err_count++;
        end
        if (got.pin_levels !== want.pin_levels) begin
          $error("pin_levels: expected %h, got %h", want.pin_levels, got.pin_levels);
          err_count++;
        end
        if (got.led_mode !== want.led_mode) begin
          $error("led_mode: expected %h, got %h", want.led_mode, got.led_mode);
          err_count++;
        end
      end
    end
  end

  // bad indices, unused request code, tick on an idle bank
  task automatic test_reset_state();
    send_item(REQ_TICK, led_item(8'd0, 8'd0, 8'd0));
    send_item(REQ_TOGGLE, led_item(8'd8, 8'd0, 8'd0));
    send_item(REQ_SET, led_item(8'hFF, 8'hFF, 8'hFF));
    send_item(REQ_UNUSED, led_item(8'd2, 8'd5, 8'd1));
    send_item(REQ_TICK, led_item(8'd200, 8'hAA, 8'h55));
    wait_drained();
  endtask

  // steady on/off under different pin polarities
  task automatic test_steady_polarity();
    send_item(REQ_SET, led_item(8'd7, MODE_ON, 8'd0));
    send_item(REQ_SET, led_item(8'd0, MODE_OFF, 8'd0));
    send_item(REQ_TICK, led_item(8'd7, 8'd0, 8'd0));
    wait_drained();
    write_level_mask(8'h00);
    send_item(REQ_TICK, led_item(8'd0, 8'd0, 8'd0));
    wait_drained();
    write_level_mask(8'h5A);
    send_item(REQ_TICK, led_item(8'd3, 8'd0, 8'd0));
    wait_drained();
  endtask

  // repeats count down on the on-edge; LED stays lit on the last one, dark after
  task automatic test_repeat_countdown();
    send_item(REQ_SET, led_item(8'd1, 8'd1, 8'd2));
    repeat (6) send_item(REQ_TICK, led_item(8'd1, 8'd0, 8'd0));
    send_item(REQ_SET, led_item(8'd5, 8'd2, 8'hFF));
    wait_drained();
  endtask

  // set without repeats inherits the phase of a same-mode LED
  task automatic test_phase_copy();
    send_item(REQ_SET, led_item(8'd3, 8'd254, 8'd0));
    send_item(REQ_SET, led_item(8'd2, 8'd3, 8'd0));
    send_item(REQ_TOGGLE, led_item(8'd2, 8'd0, 8'd0));
    send_item(REQ_SET, led_item(8'd4, 8'd3, 8'd0));
    send_item(REQ_TICK, led_item(8'd4, 8'd0, 8'd0));
    wait_drained();
  endtask

  // long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure();
    wait_drained();
    hold_requests <= hold_requests + 1;
    @(posedge clk_i);
    no_gaps = 1'b1;
    for (int k = 0; k < 12; k++)
      send_item(k[0] ? REQ_TOGGLE : REQ_SET,
                led_item(8'($urandom_range(0, LEDS - 1)), 8'($urandom_range(1, 6)),
                         8'($urandom_range(0, 2))));
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    led_req_t   it;
    logic [1:0] req;
    int         r;
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0:       write_level_mask(8'hFF);
        1:       write_level_mask(8'h00);
        default: write_level_mask(8'($urandom_range(0, 255)));
      endcase
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45)      req = REQ_TICK;
        else if (r < 75) req = REQ_SET;
        else if (r < 92) req = REQ_TOGGLE;
        else if (r < 96) req = REQ_UNUSED;
        else             req = 2'($urandom_range(0, 3));
        it.led_index = ($urandom_range(0, 7) != 0) ? 8'($urandom_range(0, LEDS - 1))
                                                   : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (req != REQ_SET)  it.mode = 8'($urandom_range(0, 255));
        else if (r < 15)     it.mode = MODE_OFF;
        else if (r < 25)     it.mode = MODE_ON;
        else if (r < 75)     it.mode = 8'($urandom_range(1, 6));
        else                 it.mode = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (req != REQ_SET)  it.repeat_count = 8'($urandom_range(0, 255));
        else if (r < 50)     it.repeat_count = 8'd0;
        else if (r < 85)     it.repeat_count = 8'($urandom_range(1, 4));
        else                 it.repeat_count = 8'($urandom_range(0, 255));
        send_item(req, it);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    hold_requests = 0;
    burst_left    = 0;
    no_gaps       = 1'b0;
    err_count     = 0;
    tick_cnt      = '0;
    level_mask    = 8'hFF;
    for (int i = 0; i < LEDS; i++) begin
      led_mode_r[i] = MODE_OFF;
      phase_r[i]    = 1'b0;
      blinks_r[i]   = '0;
      lit_r[i]      = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_steady_polarity();
    test_repeat_countdown();
    test_phase_copy();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);
    if (err_count == 0 && status_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
